// ===== rtl/bbum_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the unsharp-mask block.
package bbum_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 12;
  localparam int IMG_W_W       = 12;
  localparam int IMG_H_W       = 13;
  localparam int AMT_W         = 10;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int GEO_W         = 14;
  localparam int PIX_W         = 24;
  localparam int SUM_W         = 12;
  localparam int CNT_W         = 4;
  localparam int NUM_W         = 25;
  localparam int DIV_BITS      = 14;
  localparam int NB_LAST       = 8;
  localparam int NB_CENTER     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_RLAST, ST_MUL1, ST_MUL2, ST_DIVI, ST_DIV, ST_PUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             load_pend;
    logic             store_wr;
    logic             wr_direct;
    logic             adv_in;
    logic             rd_issue;
    logic [CNT_W-1:0] nb;
    logic             mul1;
    logic             mul2;
    logic             div_load;
    logic             div_step;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic draining;
    logic emit_ok;
    logic pend_vld;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/bbum_div.sv =====
// Restoring divider: one quotient bit per step, used once per color channel.
module bbum_div import bbum_pkg::*; (
  input  logic                clk,
  input  logic                start,
  input  logic                step,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [CNT_W-1:0]    divisor,
  output logic [DIV_BITS-1:0] quotient
);

  logic [DIV_BITS-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    dsr_r;
  logic [CNT_W:0]      trial;

  always_comb begin
    trial   = {rem_r, q_r[DIV_BITS-1]};
    q_nxt   = {q_r[DIV_BITS-2:0], 1'b0};
    rem_nxt = trial[CNT_W-1:0];
    if (trial >= {1'b0, dsr_r}) begin
      q_nxt[0] = 1'b1;
      rem_nxt  = CNT_W'(trial - {1'b0, dsr_r});
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;

endmodule

// ===== rtl/bbum_ctrl.sv =====
// Sequencer that steps one item through neighborhood reads, multiplies and division.
module bbum_ctrl import bbum_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tuser,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == REQ_FLUSH) begin
            if (sts.draining) begin
              cmd.start = 1'b1;
              k_nxt     = '0;
              state_nxt = ST_READ;
            end
          end else if (!sts.draining) begin
            if (sts.emit_ok) begin
              cmd.start     = 1'b1;
              cmd.load_pend = 1'b1;
              k_nxt         = '0;
              state_nxt     = ST_READ;
            end else begin
              cmd.store_wr  = 1'b1;
              cmd.wr_direct = 1'b1;
              cmd.adv_in    = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        cmd.nb       = k_r;
        if (k_r == CNT_W'(NB_LAST)) begin
          state_nxt = ST_RLAST;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_RLAST: begin
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        if (sts.pend_vld) begin
          cmd.store_wr = 1'b1;
          cmd.adv_in   = 1'b1;
        end
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_load = 1'b1;
        k_nxt        = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (k_r == CNT_W'(DIV_BITS - 1)) begin
          state_nxt = ST_PUT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_PUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bbum_dp.sv =====
// Datapath: configuration, frame positions, row store, neighborhood sums and sharpening math.
module bbum_dp import bbum_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [PIX_W-1:0]     in_tdata,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [PIX_W-1:0]     out_tdata,
  output logic                 out_tlast,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic [IMG_W_W-1:0] img_w_r;
  logic [IMG_H_W-1:0] img_h_r;
  logic [AMT_W-1:0]   amt_r;
  logic [GEO_W-1:0]   w_eff, h_eff;

  logic [CW-1:0]    in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [1:0]       in_m3_r, out_m3_r;
  logic             drain_r;
  logic [PIX_W-1:0] pend_r;
  logic             pend_vld_r;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;
  logic             rd_vld_r, use_r, fwd_r, ctr_r;

  logic [SUM_W-1:0]        sum_r [3];
  logic [CNT_W-1:0]        n_r;
  logic [PIX_W-1:0]        center_r;
  logic [SUM_W-1:0]        np_r [3];
  logic signed [SUM_W:0]   diff_r [3];
  logic signed [NUM_W-2:0] prod_r [3];
  logic [DIV_BITS-1:0]     dvd [3];
  logic [DIV_BITS-1:0]     quo [3];

  logic             out_vld_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  function automatic logic [AW-1:0] slot(input logic [1:0] m, input logic [CW-1:0] col);
    logic [AW-1:0] base;
    case (m)
      2'd1:    base = AW'(MAX_WIDTH);
      2'd2:    base = AW'(2 * MAX_WIDTH);
      default: base = '0;
    endcase
    return base + AW'(col);
  endfunction

  always_comb begin
    if (img_w_r == '0) w_eff = GEO_W'(1);
    else if (GEO_W'(img_w_r) > GEO_W'(MAX_WIDTH)) w_eff = GEO_W'(MAX_WIDTH);
    else w_eff = GEO_W'(img_w_r);
    if (img_h_r == '0) h_eff = GEO_W'(1);
    else if (GEO_W'(img_h_r) > GEO_W'(MAX_HEIGHT)) h_eff = GEO_W'(MAX_HEIGHT);
    else h_eff = GEO_W'(img_h_r);
  end

  // Position logic.
  logic in_last, in_wrap, out_last, out_wrap, restart;
  assign in_last  = (GEO_W'(in_row_r) >= h_eff - 1'b1) && (GEO_W'(in_col_r) >= w_eff - 1'b1);
  assign in_wrap  = GEO_W'(in_col_r) + 1'b1 >= w_eff;
  assign out_last = (GEO_W'(out_row_r) >= h_eff - 1'b1) &&
                    (GEO_W'(out_col_r) >= w_eff - 1'b1);
  assign out_wrap = GEO_W'(out_col_r) + 1'b1 >= w_eff;
  assign restart  = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_W'(640);
      img_h_r <= IMG_H_W'(480);
      amt_r   <= AMT_W'(102);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:  img_w_r <= cfg_wdata[IMG_W_W-1:0];
        REG_HEIGHT: img_h_r <= cfg_wdata[IMG_H_W-1:0];
        REG_AMOUNT: amt_r   <= cfg_wdata[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart || (cmd.out_load && out_last)) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_m3_r   <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      out_m3_r  <= '0;
      drain_r   <= 1'b0;
    end else begin
      if (cmd.adv_in) begin
        if (in_last) begin
          drain_r <= 1'b1;
        end else if (in_wrap) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 1'b1;
          in_m3_r  <= (in_m3_r == 2'd2) ? 2'd0 : in_m3_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        if (out_wrap) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + 1'b1;
          out_m3_r  <= (out_m3_r == 2'd2) ? 2'd0 : out_m3_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.load_pend) begin
      pend_vld_r <= 1'b1;
    end else if (cmd.start) begin
      pend_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pend) pend_r <= in_tdata;
  end

  // Neighborhood address for the current read step.
  logic [1:0]       dyi, dxi;
  logic [GEO_W-1:0] rr_p1, cc_p1, rr, cc;
  logic [3:0]       m3s;
  logic [1:0]       rm3;
  logic             nb_ok, nb_fwd;

  always_comb begin
    case (cmd.nb)
      4'd0:    begin dyi = 2'd0; dxi = 2'd0; end
      4'd1:    begin dyi = 2'd0; dxi = 2'd1; end
      4'd2:    begin dyi = 2'd0; dxi = 2'd2; end
      4'd3:    begin dyi = 2'd1; dxi = 2'd0; end
      4'd4:    begin dyi = 2'd1; dxi = 2'd1; end
      4'd5:    begin dyi = 2'd1; dxi = 2'd2; end
      4'd6:    begin dyi = 2'd2; dxi = 2'd0; end
      4'd7:    begin dyi = 2'd2; dxi = 2'd1; end
      default: begin dyi = 2'd2; dxi = 2'd2; end
    endcase
    rr_p1  = GEO_W'(out_row_r) + GEO_W'(dyi);
    cc_p1  = GEO_W'(out_col_r) + GEO_W'(dxi);
    rr     = rr_p1 - 1'b1;
    cc     = cc_p1 - 1'b1;
    nb_ok  = (rr_p1 != '0) && (rr_p1 <= h_eff) && (cc_p1 != '0) && (cc_p1 <= w_eff);
    nb_fwd = pend_vld_r && (rr == GEO_W'(in_row_r)) && (cc == GEO_W'(in_col_r));
    // Slot of the row above sits two rows ahead modulo three.
    m3s = {2'b00, out_m3_r} + {2'b00, dyi} + 4'd2;
    case (m3s)
      4'd1, 4'd4: rm3 = 2'd1;
      4'd2, 4'd5: rm3 = 2'd2;
      default:    rm3 = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      mem[slot(in_m3_r, in_col_r)] <= cmd.wr_direct ? in_tdata : pend_r;
    end
    if (cmd.rd_issue && nb_ok && !nb_fwd) begin
      rdata_r <= mem[slot(rm3, cc[CW-1:0])];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    use_r <= nb_ok;
    fwd_r <= nb_fwd;
    ctr_r <= (cmd.nb == CNT_W'(NB_CENTER));
  end

  logic [PIX_W-1:0] nb_val;
  assign nb_val = fwd_r ? pend_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int ch = 0; ch < 3; ch++) sum_r[ch] <= '0;
      n_r <= '0;
    end else if (rd_vld_r && use_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_r[ch] <= sum_r[ch] + SUM_W'(nb_val[8*ch +: 8]);
      end
      n_r <= n_r + 1'b1;
      if (ctr_r) center_r <= nb_val;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.mul1) begin
        np_r[ch]   <= SUM_W'(n_r * center_r[8*ch +: 8]);
        diff_r[ch] <= $signed({1'b0, SUM_W'(n_r * center_r[8*ch +: 8])}) -
                      $signed({1'b0, sum_r[ch]});
      end
      if (cmd.mul2) begin
        prod_r[ch] <= (NUM_W-1)'($signed({1'b0, amt_r}) * diff_r[ch]);
      end
    end
  end

  // Numerator 256*n*p + A*(n*p - S); a negative value clamps to zero.
  logic signed [NUM_W-1:0] num [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num[ch] = $signed({5'b0, np_r[ch], 8'b0}) + NUM_W'(prod_r[ch]);
      dvd[ch] = num[ch][NUM_W-1] ? '0 : num[ch][DIV_BITS+7:8];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    bbum_div u_div (
      .clk      (clk),
      .start    (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd[g]),
      .divisor  (n_r),
      .quotient (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_data_r[8*ch +: 8] <= (quo[ch] > DIV_BITS'(255)) ? 8'hFF : quo[ch][7:0];
      end
      out_last_r <= out_last;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign sts.draining = drain_r;
  assign sts.emit_ok  = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign sts.pend_vld = pend_vld_r;
  assign sts.out_free = !out_vld_r || out_tready;

endmodule

// ===== rtl/box_blur_unsharp_mask_top.sv =====
// Top level of the 3x3 box-blur unsharp-mask sharpener for RGB pixel streams.
// Pixels enter in raster order; each one is sharpened per channel as
// clamp(floor(p + a*(p - mean)), 0, 255) with a = sharpen_amount/256 and the
// mean taken over the in-frame 3x3 neighbors. Output lags input by width+1
// pixels; after the last pixel of a frame, flush items (in_tuser = 1) drain
// the remaining outputs one each, and pixels sent during the drain are dropped.
// A pixel that produces no output is written straight to the row store. An
// item that produces an output passes these steps before the next transfer
// can occur: the accepting step, nine reads of the single-port row store, a
// read latency step, two multiply stages, a divider load step, 14 steps of the
// bit-serial divider by the neighbor count and a step to load the output
// register. That last step stretches for as long as the output register still
// holds a result that has not been transferred. A finished result sits in the
// output register while the next item is already accepted.
// Writing image_width or image_height restarts the frame.
module box_blur_unsharp_mask_top import bbum_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,   // in_red, in_green, in_blue
  input  logic                 in_tuser,   // req_type
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,  // out_red, out_green, out_blue
  output logic                 out_tlast   // frame_end
);

  cmd_t cmd;
  sts_t sts;

  bbum_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbum_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
